### rtl/ramit_pkg.sv
// Package for the range-add / min-index lazy segment tree.
// Holds field widths, codes, and the command and status structs between
// the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package ramit_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 48;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_LIST_SIZE = 1'b0;

    typedef enum logic [1:0] {
        TS_NODE,
        TS_LC,
        TS_RC
    } t_tsel;

    typedef enum logic [2:0] {
        AD_CLR,
        AD_TGT,
        AD_TC1,
        AD_TC2,
        AD_NODE,
        AD_LC,
        AD_RC
    } t_asel;

    typedef enum logic [2:0] {
        W_ZERO,
        W_PUSH,
        W_CHILD,
        W_LEAF,
        W_COVER,
        W_RECOMP
    } t_wsel;

    typedef struct packed {
        logic  accept;
        logic  root;
        logic  tgt_load;
        t_tsel tgt_sel;
        logic  p_cap;
        logic  p_from_v;
        logic  lmin_q;
        logic  lmin_p;
        logic  root_cap;
        logic  desc;
        logic  desc_right;
        logic  pop;
        logic  step;
        logic  out_load;
        logic  clr_rst;
        logic  we;
        t_asel asel;
        t_wsel wsel;
    } t_cmd;

    typedef struct packed {
        logic leaf;
        logic tgt_leaf;
        logic pend_nz;
        logic disjoint;
        logic covered;
        logic pos_left;
        logic sp_zero;
        logic phase;
        logic clr_last;
        logic skip_load;
        logic is_add;
    } t_status;

endpackage

### rtl/ramit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ramit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ramit_ctrl.sv
// Controller of the lazy segment tree: sequences pushes, the recursion,
// recompute, the min-index descent and the clearing pass.
// Depends on ramit_pkg.
`timescale 1ns / 1ps

module ramit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ramit_pkg::t_status i_st,
    output ramit_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_START, S_VISIT, S_VAFT, S_VRC, S_VDESC,
        S_PRD, S_PCHK, S_PC1R, S_PC1W, S_PC2R, S_PC2W,
        S_RET, S_POPD, S_RC1, S_RC2, S_RC3,
        S_FIN, S_FPUSH, S_FROOT, S_DLOOP, S_DL, S_DR, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_out_valid, n_out_valid;
    ramit_pkg::t_cmd c;

    always_comb begin
        c           = '0;
        c.tgt_sel   = ramit_pkg::TS_NODE;
        c.asel      = ramit_pkg::AD_NODE;
        c.wsel      = ramit_pkg::W_ZERO;
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLR: begin
                c.we   = 1'b1;
                c.asel = ramit_pkg::AD_CLR;
                c.wsel = ramit_pkg::W_ZERO;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    c.accept = 1'b1;
                    n_state  = S_START;
                end
            end
            S_START: begin
                n_state = i_st.skip_load ? S_FIN : S_VISIT;
            end
            S_VISIT: begin
                c.tgt_load = 1'b1;
                c.tgt_sel  = ramit_pkg::TS_NODE;
                n_ret      = S_VAFT;
                n_state    = S_PRD;
            end
            // push_down subroutine on the target node
            S_PRD: begin
                c.asel  = ramit_pkg::AD_TGT;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                c.asel  = ramit_pkg::AD_TGT;
                c.p_cap = 1'b1;
                if (i_st.pend_nz) begin
                    c.we   = 1'b1;
                    c.wsel = ramit_pkg::W_PUSH;
                    n_state = i_st.tgt_leaf ? r_ret : S_PC1R;
                end else begin
                    n_state = r_ret;
                end
            end
            S_PC1R: begin
                c.asel  = ramit_pkg::AD_TC1;
                n_state = S_PC1W;
            end
            S_PC1W: begin
                c.asel  = ramit_pkg::AD_TC1;
                c.we    = 1'b1;
                c.wsel  = ramit_pkg::W_CHILD;
                n_state = S_PC2R;
            end
            S_PC2R: begin
                c.asel  = ramit_pkg::AD_TC2;
                n_state = S_PC2W;
            end
            S_PC2W: begin
                c.asel  = ramit_pkg::AD_TC2;
                c.we    = 1'b1;
                c.wsel  = ramit_pkg::W_CHILD;
                n_state = r_ret;
            end
            // node visit after its own push
            S_VAFT: begin
                if (!i_st.is_add) begin
                    if (i_st.leaf) begin
                        c.we    = 1'b1;
                        c.asel  = ramit_pkg::AD_NODE;
                        c.wsel  = ramit_pkg::W_LEAF;
                        n_state = S_RET;
                    end else begin
                        c.tgt_load = 1'b1;
                        c.tgt_sel  = ramit_pkg::TS_LC;
                        n_ret      = S_VRC;
                        n_state    = S_PRD;
                    end
                end else if (i_st.disjoint) begin
                    n_state = S_RET;
                end else if (i_st.covered) begin
                    c.we       = 1'b1;
                    c.asel     = ramit_pkg::AD_NODE;
                    c.wsel     = ramit_pkg::W_COVER;
                    c.p_from_v = 1'b1;
                    n_ret      = S_RET;
                    n_state    = i_st.leaf ? S_RET : S_PC1R;
                end else begin
                    c.desc  = 1'b1;
                    n_state = S_VISIT;
                end
            end
            S_VRC: begin
                c.tgt_load = 1'b1;
                c.tgt_sel  = ramit_pkg::TS_RC;
                n_ret      = S_VDESC;
                n_state    = S_PRD;
            end
            S_VDESC: begin
                c.desc       = 1'b1;
                c.desc_right = !i_st.pos_left;
                n_state      = S_VISIT;
            end
            // return from a visit
            S_RET: begin
                if (i_st.sp_zero) begin
                    n_state = S_FIN;
                end else begin
                    c.pop   = 1'b1;
                    n_state = S_POPD;
                end
            end
            S_POPD: begin
                if (i_st.is_add && !i_st.phase) begin
                    c.desc       = 1'b1;
                    c.desc_right = 1'b1;
                    n_state      = S_VISIT;
                end else begin
                    n_state = S_RC1;
                end
            end
            S_RC1: begin
                c.asel  = ramit_pkg::AD_LC;
                n_state = S_RC2;
            end
            S_RC2: begin
                c.asel   = ramit_pkg::AD_RC;
                c.lmin_q = 1'b1;
                n_state  = S_RC3;
            end
            S_RC3: begin
                c.we    = 1'b1;
                c.asel  = ramit_pkg::AD_NODE;
                c.wsel  = ramit_pkg::W_RECOMP;
                n_state = S_RET;
            end
            // root push and min-index descent
            S_FIN: begin
                c.root  = 1'b1;
                n_state = S_FPUSH;
            end
            S_FPUSH: begin
                c.tgt_load = 1'b1;
                c.tgt_sel  = ramit_pkg::TS_NODE;
                n_ret      = S_FROOT;
                n_state    = S_PRD;
            end
            S_FROOT: begin
                c.root_cap = 1'b1;
                n_state    = S_DLOOP;
            end
            S_DLOOP: begin
                if (!i_st.leaf) begin
                    c.tgt_load = 1'b1;
                    c.tgt_sel  = ramit_pkg::TS_LC;
                    n_ret      = S_DL;
                    n_state    = S_PRD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DL: begin
                c.lmin_p   = 1'b1;
                c.tgt_load = 1'b1;
                c.tgt_sel  = ramit_pkg::TS_RC;
                n_ret      = S_DR;
                n_state    = S_PRD;
            end
            S_DR: begin
                c.step  = 1'b1;
                n_state = S_DLOOP;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    c.out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
        // a list_size write restarts the clearing pass
        if (i_cfg_wr) begin
            c.clr_rst = 1'b1;
            c.we      = 1'b0;
            n_state   = S_CLR;
        end
    end

    // hold state and the registered output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = c;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/ramit_dp.sv
// Datapath of the lazy segment tree: node memory, frame registers,
// recursion stack, adders and compares, result registers.
// Depends on ramit_pkg and ramit_ram.
`timescale 1ns / 1ps

module ramit_dp #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int TREE_NODES   = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ramit_pkg::t_cmd                i_cmd,
    output ramit_pkg::t_status             o_st,
    input  logic [ramit_pkg::SIZE_W-1:0]   i_list_size,
    input  logic                           i_op,
    input  logic [ramit_pkg::IDX_W-1:0]    i_first,
    input  logic [ramit_pkg::IDX_W-1:0]    i_last,
    input  logic [ramit_pkg::DATA_W-1:0]   i_value,
    output logic [ramit_pkg::IDX_W-1:0]    o_min_index,
    output logic [ramit_pkg::DATA_W-1:0]   o_min_value
);

    localparam int DW  = ramit_pkg::DATA_W;
    localparam int AW  = $clog2(TREE_NODES);
    localparam int LW  = $clog2(MAX_ELEMENTS) + 1;
    localparam int CW  = (LW > ramit_pkg::SIZE_W) ? LW : ramit_pkg::SIZE_W;
    localparam int SD  = $clog2(MAX_ELEMENTS) + 1;
    localparam int SW  = $clog2(SD);
    localparam int PW  = $clog2(SD + 1);

    // item registers
    logic          r_op;
    logic [CW-1:0] r_a, r_b;
    logic [DW-1:0] r_val;

    // current frame and push target
    logic [AW-1:0] r_node, r_tgt;
    logic [CW-1:0] r_lo, r_hi;
    logic          r_tgt_leaf;

    logic [DW-1:0] r_p, r_pmin, r_lmin, r_rootmin;
    logic [AW-1:0] r_clr;

    // recursion stack
    logic [AW-1:0] r_stk_node [SD];
    logic [CW-1:0] r_stk_lo   [SD];
    logic [CW-1:0] r_stk_hi   [SD];
    logic          r_stk_ph   [SD];
    logic [PW-1:0] r_sp;
    logic          r_phase;

    logic [ramit_pkg::IDX_W-1:0] r_out_idx;
    logic [DW-1:0]               r_out_val;

    logic [CW:0]     w_sum;
    logic [CW-1:0]   w_mid, w_mid1, w_size_m1;
    logic [AW-1:0]   w_lc, w_rc, w_tc1, w_tc2, w_addr;
    logic [PW-1:0]   w_sp_m1;
    logic [2*DW-1:0] w_q, w_wdata;
    logic [DW-1:0]   w_qmin, w_qpend, w_recomp;
    logic            w_tleaf;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[CW:1];
    assign w_mid1    = w_mid + CW'(1);
    assign w_size_m1 = CW'(i_list_size) - CW'(1);
    assign w_lc      = {r_node[AW-2:0], 1'b1};
    assign w_rc      = w_lc + AW'(1);
    assign w_tc1     = {r_tgt[AW-2:0], 1'b1};
    assign w_tc2     = w_tc1 + AW'(1);
    assign w_sp_m1   = r_sp - PW'(1);
    assign w_qmin    = w_q[DW-1:0];
    assign w_qpend   = w_q[2*DW-1:DW];
    assign w_recomp  = ($signed(w_qmin) < $signed(r_lmin)) ? w_qmin : r_lmin;

    // leaf flag of the node a push is aimed at
    always_comb begin
        unique case (i_cmd.tgt_sel)
            ramit_pkg::TS_LC: w_tleaf = (r_lo == w_mid);
            ramit_pkg::TS_RC: w_tleaf = (w_mid1 == r_hi);
            default:          w_tleaf = (r_lo == r_hi);
        endcase
    end

    // memory address select
    always_comb begin
        unique case (i_cmd.asel)
            ramit_pkg::AD_CLR: w_addr = r_clr;
            ramit_pkg::AD_TGT: w_addr = r_tgt;
            ramit_pkg::AD_TC1: w_addr = w_tc1;
            ramit_pkg::AD_TC2: w_addr = w_tc2;
            ramit_pkg::AD_LC:  w_addr = w_lc;
            ramit_pkg::AD_RC:  w_addr = w_rc;
            default:           w_addr = r_node;
        endcase
    end

    // memory write data: pending add in the upper half, minimum below
    always_comb begin
        unique case (i_cmd.wsel)
            ramit_pkg::W_PUSH:   w_wdata = {{DW{1'b0}}, w_qmin + w_qpend};
            ramit_pkg::W_CHILD:  w_wdata = {w_qpend + r_p, w_qmin};
            ramit_pkg::W_LEAF:   w_wdata = {{DW{1'b0}}, r_val};
            ramit_pkg::W_COVER:  w_wdata = {{DW{1'b0}}, r_pmin + r_val};
            ramit_pkg::W_RECOMP: w_wdata = {{DW{1'b0}}, w_recomp};
            default:             w_wdata = '0;
        endcase
    end

    ramit_ram #(
        .WIDTH (2 * DW),
        .DEPTH (TREE_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_q)
    );

    // control registers: clear counter and stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_sp  <= '0;
        end else begin
            if (i_cmd.clr_rst) begin
                r_clr <= '0;
            end else if (i_cmd.we && i_cmd.asel == ramit_pkg::AD_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.accept || i_cmd.clr_rst) begin
                r_sp <= '0;
            end else if (i_cmd.desc) begin
                r_sp <= r_sp + PW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= w_sp_m1;
            end
        end
    end

    // frame, stack and value registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_a   <= CW'(i_first);
            r_b   <= CW'(i_last);
            r_val <= i_value;
        end
        if (i_cmd.accept || i_cmd.root) begin
            r_node <= '0;
            r_lo   <= '0;
            r_hi   <= w_size_m1;
        end else if (i_cmd.desc || i_cmd.step) begin
            if (i_cmd.desc ? i_cmd.desc_right
                           : !($signed(r_lmin) < $signed(r_pmin))) begin
                r_node <= w_rc;
                r_lo   <= w_mid1;
            end else begin
                r_node <= w_lc;
                r_hi   <= w_mid;
            end
        end else if (i_cmd.pop) begin
            r_node  <= r_stk_node[w_sp_m1[SW-1:0]];
            r_lo    <= r_stk_lo[w_sp_m1[SW-1:0]];
            r_hi    <= r_stk_hi[w_sp_m1[SW-1:0]];
            r_phase <= r_stk_ph[w_sp_m1[SW-1:0]];
        end
        if (i_cmd.desc) begin
            r_stk_node[r_sp[SW-1:0]] <= r_node;
            r_stk_lo[r_sp[SW-1:0]]   <= r_lo;
            r_stk_hi[r_sp[SW-1:0]]   <= r_hi;
            r_stk_ph[r_sp[SW-1:0]]   <= i_cmd.desc_right;
        end
        if (i_cmd.tgt_load) begin
            r_tgt      <= (i_cmd.tgt_sel == ramit_pkg::TS_LC) ? w_lc :
                          (i_cmd.tgt_sel == ramit_pkg::TS_RC) ? w_rc : r_node;
            r_tgt_leaf <= w_tleaf;
        end
        if (i_cmd.p_cap) begin
            r_p    <= w_qpend;
            r_pmin <= w_qmin + w_qpend;
        end else if (i_cmd.p_from_v) begin
            r_p <= r_val;
        end
        if (i_cmd.lmin_q) begin
            r_lmin <= w_qmin;
        end else if (i_cmd.lmin_p) begin
            r_lmin <= r_pmin;
        end
        if (i_cmd.root_cap) begin
            r_rootmin <= r_pmin;
        end
        if (i_cmd.out_load) begin
            r_out_idx <= r_lo[ramit_pkg::IDX_W-1:0];
            r_out_val <= r_rootmin;
        end
    end

    // status back to the controller
    always_comb begin
        o_st           = '0;
        o_st.leaf      = (r_lo == r_hi);
        o_st.tgt_leaf  = r_tgt_leaf;
        o_st.pend_nz   = (w_qpend != '0);
        o_st.disjoint  = (r_b < r_lo) || (r_hi < r_a);
        o_st.covered   = (r_a <= r_lo) && (r_hi <= r_b);
        o_st.pos_left  = (r_a <= w_mid);
        o_st.sp_zero   = (r_sp == '0);
        o_st.phase     = r_phase;
        o_st.clr_last  = (r_clr == AW'(TREE_NODES - 1));
        o_st.skip_load = (r_op == ramit_pkg::OP_LOAD) && (r_a >= CW'(i_list_size));
        o_st.is_add    = (r_op == ramit_pkg::OP_ADD);
    end

    assign o_min_index = r_out_idx;
    assign o_min_value = r_out_val;

endmodule

### rtl/range_add_min_index_tree.sv
// Top level of the range-add / min-index lazy segment tree: stream ports,
// APB register, controller and datapath.
// Depends on ramit_pkg, ramit_ctrl, ramit_dp.
//
//  channel   direction  transfer when              payload
//  s_*       in         s_tvalid & s_tready        operation, indices, value
//  m_*       out        m_tvalid & m_tready        min_index, min_value
//  apb       in/out     psel&penable&pwrite        list_size at address 0
//
// One item at a time; a node push reads the node, and when a pending add
// moves to the children it reads and writes each child in turn. A load
// pushes the node and both children at every tree level, a range add visits
// up to four nodes per level, and the min-index descent pushes both children.
// All steps run in series, since the node memory sees one address at a time.
// After reset and after each list_size write a clearing pass over all
// TREE_NODES nodes runs with s_tready low. A result held on m_* stalls the next one.
`timescale 1ns / 1ps

module range_add_min_index_tree #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int TREE_NODES   = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] operation, [10:1] first_index, [20:11] last_index, [52:21] value
    input  logic [ramit_pkg::IN_W-1:0]      s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] min_index, [41:10] min_value
    output logic [ramit_pkg::OUT_W-1:0]     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ramit_pkg::PADDR_W-1:0]   paddr,
    input  logic [ramit_pkg::PDATA_W-1:0]   pwdata,
    output logic [ramit_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);

    localparam int SZ = ramit_pkg::SIZE_W;

    logic [SZ-1:0]              r_list_size, n_list_size;
    logic                       w_cfg_wr;
    ramit_pkg::t_cmd            w_cmd;
    ramit_pkg::t_status         w_st;
    logic [ramit_pkg::IDX_W-1:0]  w_min_index;
    logic [ramit_pkg::DATA_W-1:0] w_min_value;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == ramit_pkg::REG_LIST_SIZE);

    // clamp the written size to 1..MAX_ELEMENTS
    always_comb begin
        n_list_size = pwdata[SZ-1:0];
        if (n_list_size == '0) begin
            n_list_size = SZ'(1);
        end else if (32'(n_list_size) > 32'(MAX_ELEMENTS)) begin
            n_list_size = SZ'(MAX_ELEMENTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_size <= SZ'(MAX_ELEMENTS);
        end else if (w_cfg_wr) begin
            r_list_size <= n_list_size;
        end
    end

    assign prdata = (paddr[2] == ramit_pkg::REG_LIST_SIZE)
                  ? ramit_pkg::PDATA_W'(r_list_size) : '0;

    ramit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    ramit_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TREE_NODES   (TREE_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_list_size (r_list_size),
        .i_op        (s_tdata[0]),
        .i_first     (s_tdata[10:1]),
        .i_last      (s_tdata[20:11]),
        .i_value     (s_tdata[52:21]),
        .o_min_index (w_min_index),
        .o_min_value (w_min_value)
    );

    assign m_tdata = {6'b0, w_min_value, w_min_index};

endmodule

### rtl/ramit_chk.sv
// Port-level checker for range_add_min_index_tree, attached by bind.
// Depends on ramit_pkg.
`timescale 1ns / 1ps

module ramit_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ramit_pkg::OUT_W-1:0]   m_tdata,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [ramit_pkg::PADDR_W-1:0] paddr,
    input logic                          pready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // drop ready after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a size write starts the clearing pass
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == ramit_pkg::REG_LIST_SIZE)
        |=> !s_tready)
        else $error("no clearing pass after size write");

    // a result only appears while the input side is busy
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without an item in work");

endmodule

bind range_add_min_index_tree ramit_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pready   (pready)
);

### tb/tree_min_checker.sv
// Checker for range_add_min_index_tree: watches the stream and APB ports,
// keeps its own lazy min tree and compares every result transfer.
// Depends on ramit_pkg.
`timescale 1ns / 1ps

module tree_min_checker #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int TREE_NODES   = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [ramit_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [ramit_pkg::OUT_W-1:0]   i_m_tdata,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [ramit_pkg::PADDR_W-1:0] i_paddr,
    input  logic [ramit_pkg::PDATA_W-1:0] i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ramit_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  min_index;
        logic [DATA_W-1:0] min_value;
    } t_min_result;

    logic [DATA_W-1:0] node_min [TREE_NODES];
    logic [DATA_W-1:0] node_pend [TREE_NODES];
    int                elem_count;
    t_min_result       min_result_q[$];

    function automatic bit less_than(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [DATA_W-1:0] node_value(int node);
        return node < TREE_NODES ? node_min[node] : '0;
    endfunction

    function automatic void add_to_pend(int node, logic [DATA_W-1:0] amount);
        if (node < TREE_NODES) node_pend[node] += amount;
    endfunction

    function automatic void clear_tree();
        for (int i = 0; i < TREE_NODES; i++) begin
            node_min[i]  = '0;
            node_pend[i] = '0;
        end
    endfunction

    // fold a node's pending add into its minimum, pass it to the children
    function automatic void settle(int node, int lo, int hi);
        logic [DATA_W-1:0] p;
        if (node >= TREE_NODES) return;
        p = node_pend[node];
        if (p != 0) begin
            node_min[node] += p;
            if (lo < hi) begin
                add_to_pend(2 * node + 1, p);
                add_to_pend(2 * node + 2, p);
            end
            node_pend[node] = '0;
        end
    endfunction

    function automatic void load_element(int node, int lo, int hi, int pos,
                                         logic [DATA_W-1:0] v);
        int mid;
        if (node >= TREE_NODES) return;
        settle(node, lo, hi);
        if (lo == hi) begin
            node_min[node] = v;
            return;
        end
        mid = (lo + hi) / 2;
        settle(2 * node + 1, lo, mid);
        settle(2 * node + 2, mid + 1, hi);
        if (pos <= mid) load_element(2 * node + 1, lo, mid, pos, v);
        else load_element(2 * node + 2, mid + 1, hi, pos, v);
        node_min[node] = less_than(node_value(2 * node + 2), node_value(2 * node + 1))
                       ? node_value(2 * node + 2) : node_value(2 * node + 1);
    endfunction

    function automatic void add_over_range(int node, int lo, int hi, int a, int b,
                                           logic [DATA_W-1:0] v);
        int mid;
        if (node >= TREE_NODES) return;
        settle(node, lo, hi);
        if (b < lo || hi < a) return;
        if (a <= lo && hi <= b) begin
            node_min[node] += v;
            if (lo < hi) begin
                add_to_pend(2 * node + 1, v);
                add_to_pend(2 * node + 2, v);
            end
            return;
        end
        mid = (lo + hi) / 2;
        add_over_range(2 * node + 1, lo, mid, a, b, v);
        add_over_range(2 * node + 2, mid + 1, hi, a, b, v);
        node_min[node] = less_than(node_value(2 * node + 2), node_value(2 * node + 1))
                       ? node_value(2 * node + 2) : node_value(2 * node + 1);
    endfunction

    // descend from the root; go left only on a strictly smaller left child
    function automatic int locate_min();
        int lo, hi, node, mid;
        lo = 0;
        hi = elem_count - 1;
        node = 0;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            settle(2 * node + 1, lo, mid);
            settle(2 * node + 2, mid + 1, hi);
            if (less_than(node_value(2 * node + 1), node_value(2 * node + 2))) begin
                node = 2 * node + 1;
                hi = mid;
            end else begin
                node = 2 * node + 2;
                lo = mid + 1;
            end
        end
        return lo;
    endfunction

    function automatic t_min_result apply_item(logic [IN_W-1:0] d);
        logic              op;
        int                first, last;
        logic [DATA_W-1:0] v;
        t_min_result       r;
        op    = d[0];
        first = d[10:1];
        last  = d[20:11];
        v     = d[52:21];
        if (op == OP_LOAD) begin
            if (first < elem_count) load_element(0, 0, elem_count - 1, first, v);
        end else begin
            add_over_range(0, 0, elem_count - 1, first, last, v);
        end
        settle(0, 0, elem_count - 1);
        r.min_index = IDX_W'(locate_min());
        r.min_value = node_value(0);
        return r;
    endfunction

    assign o_pending = min_result_q.size();

    initial begin
        o_fail_count = 0;
        elem_count   = MAX_ELEMENTS;
        clear_tree();
    end

    always @(posedge i_clk) begin
        int          n;
        t_min_result got, want;
        if (!i_rst_n) begin
            elem_count = MAX_ELEMENTS;
            clear_tree();
            min_result_q.delete();
        end else begin
            // register write: clamp the size and clear the tree
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_LIST_SIZE) begin
                n = i_pwdata[SIZE_W-1:0];
                if (n < 1) n = 1;
                if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
                elem_count = n;
                clear_tree();
            end
            if (i_s_tvalid && i_s_tready)
                min_result_q.push_back(apply_item(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[9:0], i_m_tdata[41:10]};
                if (min_result_q.size() == 0) begin
                    $display("%0t: unexpected result: actual index %0d value %0d",
                             $time, got.min_index, $signed(got.min_value));
                    o_fail_count++;
                end else begin
                    want = min_result_q.pop_front();
                    if (got.min_index !== want.min_index) begin
                        $display("%0t: min_index expected %0d actual %0d",
                                 $time, want.min_index, got.min_index);
                        o_fail_count++;
                    end
                    if (got.min_value !== want.min_value) begin
                        $display("%0t: min_value expected %0d actual %0d", $time,
                                 $signed(want.min_value), $signed(got.min_value));
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/testbench.sv
// Top of the range_add_min_index_tree test: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on ramit_pkg,
// tree_min_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
    import ramit_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // [0] operation, [10:1] first_index, [20:11] last_index, [52:21] value
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [9:0] min_index, [41:10] min_value
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata, prdata;
    int                   fail_count, pending;
    int                   send_idle_pct, recv_idle_pct;
    int                   items_sent;
    int                   elem_count;
    bit                   hold_request;
    int                   hold_left;

    range_add_min_index_tree dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tree_min_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest correct run
    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stalls, plus a long counted hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // set the idle mix from how far the run has come
    function automatic void pick_idling();
        if (items_sent < 160) begin
            send_idle_pct = 28;
            recv_idle_pct = 72;
        end else if (items_sent < 320) begin
            send_idle_pct = 72;
            recv_idle_pct = 28;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    task automatic send_item(logic op, int first, int last, logic [DATA_W-1:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, v, last[IDX_W-1:0], first[IDX_W-1:0], op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        pick_idling();
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // drain all results, then write list_size in a setup and an access cycle
    task automatic write_list_size(logic [PDATA_W-1:0] v);
        int n;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n = v[SIZE_W-1:0];
        elem_count = n < 1 ? 1 : (n > 1024 ? 1024 : n);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return DATA_W'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_index();
        if ($urandom_range(0, 99) < 12) return $urandom_range(0, 1023);
        return $urandom_range(0, elem_count - 1);
    endfunction

    // mostly well-formed loads and adds inside the list, some stray ones
    task automatic random_items(int count);
        int a, b;
        for (int k = 0; k < count; k++) begin
            a = pick_index();
            b = pick_index();
            if ($urandom_range(0, 99) < 80 && a > b) begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            if ($urandom_range(0, 1)) send_item(OP_LOAD, a, b, pick_value());
            else send_item(OP_ADD, a, b, pick_value());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_request  = 1'b0;
        items_sent    = 0;
        elem_count    = 1024;
        send_idle_pct = 28;
        recv_idle_pct = 72;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ties, wrap, reversed and partly outside ranges
        send_item(OP_LOAD, 0, 0, 32'h7fff_ffff);
        send_item(OP_LOAD, 1023, 1023, 32'h8000_0000);
        send_item(OP_ADD, 0, 1023, 32'h7fff_ffff);
        send_item(OP_ADD, 1023, 1023, 32'h0000_0001);
        send_item(OP_ADD, 512, 511, 32'hffff_ffff);
        send_item(OP_ADD, 0, 1023, 32'h8000_0000);
        send_item(OP_LOAD, 1023, 0, 32'h0000_0000);
        send_item(OP_LOAD, 511, 0, 32'hffff_ffff);
        send_item(OP_LOAD, 512, 0, 32'hffff_ffff);
        send_item(OP_ADD, 511, 512, 32'h0000_0002);
        send_item(OP_ADD, 300, 700, 32'h8000_0001);
        send_item(OP_ADD, 1023, 0, 32'h1234_5678);
        send_item(OP_LOAD, 341, 682, 32'h5555_5555);
        send_item(OP_ADD, 682, 682, 32'haaaa_aaaa);

        write_list_size(32'd5);
        send_item(OP_LOAD, 7, 0, 32'h8000_0000);
        send_item(OP_ADD, 3, 1023, 32'hffff_fff0);
        send_item(OP_ADD, 4, 2, 32'h0000_0100);
        send_item(OP_LOAD, 4, 0, 32'h8000_0000);
        send_item(OP_LOAD, 0, 0, 32'h8000_0000);
        send_item(OP_ADD, 0, 4, 32'h0000_0000);
        random_items(15);

        write_list_size(32'd1);
        random_items(20);
        write_list_size(32'd2);
        random_items(30);
        write_list_size(32'd3);
        random_items(30);
        write_list_size(32'h0000_f800);
        random_items(15);

        write_list_size(32'd17);
        random_items(5);
        hold_request = 1'b1;
        random_items(75);

        // wait out every result before carrying on
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_items(20);

        write_list_size(32'd1024);
        random_items(10);
        hold_request = 1'b1;
        random_items(90);
        write_list_size(32'h0000_07ff);
        random_items(60);
        write_list_size(32'd100);
        random_items(80);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
